// ===== sv/sdiv_pkg.sv =====
// ----------------------------------------------------------------------------
// sdiv_pkg
// Shared constants and types for the pipelined signed divider.
// ----------------------------------------------------------------------------
package sdiv_pkg;

  localparam int SDIV_DATA_WIDTH = 32;

  // Sign and special-case flags that travel with each transaction.
  typedef struct packed {
    logic a_neg;   // dividend negative: remainder takes this sign
    logic q_neg;   // operand signs differ: quotient is negated
    logic b_zero;  // divisor is zero: quotient forced to zero
  } sdiv_flags_t;

endpackage

// ===== sv/signed_divide_with_remainder.sv =====
// ----------------------------------------------------------------------------
// signed_divide_with_remainder
// Fully pipelined signed divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
//  channel  ports                                        direction
//  in       in_valid/in_stall, in_dividend, in_divisor   into block
//  out      out_valid/out_stall, out_quotient,           out of block
//           out_remainder, out_quotient_magnitude
//
//  There is one magnitude stage, one restoring step per quotient bit and one
//  sign stage. One transaction enters per cycle while in_stall is low.
//  Every stage holds its own valid bit; a stage takes new data when empty or
//  when the stage after it moves, so bubbles close up under out_stall.
//  Synchronous active-low reset empties the pipeline.
// ----------------------------------------------------------------------------
module signed_divide_with_remainder import sdiv_pkg::*; #(
  parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_dividend,
  input  logic signed [DATA_WIDTH-1:0] in_divisor,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_quotient,
  output logic signed [DATA_WIDTH-1:0] out_remainder,
  output logic        [DATA_WIDTH-1:0] out_quotient_magnitude
);

  logic                  st_valid [0:DATA_WIDTH];
  logic                  st_stall [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] st_rem   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] st_quo   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] st_dvs   [0:DATA_WIDTH];
  sdiv_flags_t           st_flags [0:DATA_WIDTH];
  logic                  fix_stall;

  assign st_rem[0] = '0;

  sdiv_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .dividend (in_dividend),
    .divisor  (in_divisor),
    .dn_valid (st_valid[0]),
    .dn_stall (st_stall[0]),
    .dvd_mag  (st_quo[0]),
    .dvs_mag  (st_dvs[0]),
    .flags    (st_flags[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    sdiv_step #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (st_valid[i]),
      .up_stall  (st_stall[i]),
      .rem_in    (st_rem[i]),
      .quo_in    (st_quo[i]),
      .dvs_in    (st_dvs[i]),
      .flags_in  (st_flags[i]),
      .dn_valid  (st_valid[i+1]),
      .dn_stall  (st_stall[i+1]),
      .rem_out   (st_rem[i+1]),
      .quo_out   (st_quo[i+1]),
      .dvs_out   (st_dvs[i+1]),
      .flags_out (st_flags[i+1])
    );
  end

  assign st_stall[DATA_WIDTH] = fix_stall;

  sdiv_fix #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_fix (
    .clk                (clk),
    .rst_n              (rst_n),
    .up_valid           (st_valid[DATA_WIDTH]),
    .up_stall           (fix_stall),
    .rem_mag            (st_rem[DATA_WIDTH]),
    .quo_mag            (st_quo[DATA_WIDTH]),
    .flags              (st_flags[DATA_WIDTH]),
    .dn_valid           (out_valid),
    .dn_stall           (out_stall),
    .quotient           (out_quotient),
    .remainder          (out_remainder),
    .quotient_magnitude (out_quotient_magnitude)
  );

  // divisor magnitude of the final stage is not needed past the last step
  logic unused_dvs;
  assign unused_dvs = ^st_dvs[DATA_WIDTH];

endmodule

// ===== sv/sdiv_prep.sv =====
// ----------------------------------------------------------------------------
// sdiv_prep
// Input stage: takes operand magnitudes and records the sign and zero-divisor flags.
// ----------------------------------------------------------------------------
module sdiv_prep import sdiv_pkg::*; #(
  parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_stall,
  input  logic signed [DATA_WIDTH-1:0] dividend,
  input  logic signed [DATA_WIDTH-1:0] divisor,
  output logic                         dn_valid,
  input  logic                         dn_stall,
  output logic        [DATA_WIDTH-1:0] dvd_mag,
  output logic        [DATA_WIDTH-1:0] dvs_mag,
  output sdiv_flags_t                  flags
);

  logic                  valid_r;
  logic [DATA_WIDTH-1:0] dvd_mag_r, dvd_mag_nxt;
  logic [DATA_WIDTH-1:0] dvs_mag_r, dvs_mag_nxt;
  sdiv_flags_t           flags_r, flags_nxt;
  logic                  a_neg, b_neg;

  assign up_stall = valid_r & dn_stall;

  always_comb begin
    a_neg             = dividend[DATA_WIDTH-1];
    b_neg             = divisor[DATA_WIDTH-1];
    dvd_mag_nxt       = a_neg ? (~dividend + 1'b1) : dividend;
    dvs_mag_nxt       = b_neg ? (~divisor + 1'b1) : divisor;
    flags_nxt.a_neg   = a_neg;
    flags_nxt.q_neg   = a_neg ^ b_neg;
    flags_nxt.b_zero  = (divisor == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      dvd_mag_r <= dvd_mag_nxt;
      dvs_mag_r <= dvs_mag_nxt;
      flags_r   <= flags_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dvd_mag  = dvd_mag_r;
  assign dvs_mag  = dvs_mag_r;
  assign flags    = flags_r;

endmodule

// ===== sv/sdiv_step.sv =====
// ----------------------------------------------------------------------------
// sdiv_step
// One restoring-division stage: retires one quotient bit per transaction.
// ----------------------------------------------------------------------------
module sdiv_step import sdiv_pkg::*; #(
  parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_stall,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] quo_in,
  input  logic [DATA_WIDTH-1:0] dvs_in,
  input  sdiv_flags_t           flags_in,
  output logic                  dn_valid,
  input  logic                  dn_stall,
  output logic [DATA_WIDTH-1:0] rem_out,
  output logic [DATA_WIDTH-1:0] quo_out,
  output logic [DATA_WIDTH-1:0] dvs_out,
  output sdiv_flags_t           flags_out
);

  logic                  valid_r;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] dvs_r;
  sdiv_flags_t           flags_r;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  q_bit;

  assign up_stall = valid_r & dn_stall;

  // quo holds unprocessed dividend bits at the top, quotient bits shift in below
  always_comb begin
    trial   = {rem_in, quo_in[DATA_WIDTH-1]};
    diff    = trial - {1'b0, dvs_in};
    q_bit   = ~diff[DATA_WIDTH];
    rem_nxt = q_bit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    quo_nxt = {quo_in[DATA_WIDTH-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      rem_r   <= rem_nxt;
      quo_r   <= quo_nxt;
      dvs_r   <= dvs_in;
      flags_r <= flags_in;
    end
  end

  assign dn_valid  = valid_r;
  assign rem_out   = rem_r;
  assign quo_out   = quo_r;
  assign dvs_out   = dvs_r;
  assign flags_out = flags_r;

endmodule

// ===== sv/sdiv_fix.sv =====
// ----------------------------------------------------------------------------
// sdiv_fix
// Output stage: applies signs, handles a zero divisor, holds the result.
// ----------------------------------------------------------------------------
module sdiv_fix import sdiv_pkg::*; #(
  parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_stall,
  input  logic        [DATA_WIDTH-1:0] rem_mag,
  input  logic        [DATA_WIDTH-1:0] quo_mag,
  input  sdiv_flags_t                  flags,
  output logic                         dn_valid,
  input  logic                         dn_stall,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic signed [DATA_WIDTH-1:0] remainder,
  output logic        [DATA_WIDTH-1:0] quotient_magnitude
);

  logic                  valid_r;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] qmag_r, qmag_nxt;

  assign up_stall = valid_r & dn_stall;

  // With a zero divisor the remainder path already yields the dividend
  // magnitude, so only the quotient needs overriding.
  always_comb begin
    qmag_nxt = flags.b_zero ? '0 : quo_mag;
    quo_nxt  = flags.q_neg ? (~qmag_nxt + 1'b1) : qmag_nxt;
    rem_nxt  = flags.a_neg ? (~rem_mag + 1'b1) : rem_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      qmag_r <= qmag_nxt;
    end
  end

  assign dn_valid           = valid_r;
  assign quotient           = quo_r;
  assign remainder          = rem_r;
  assign quotient_magnitude = qmag_r;

endmodule
